// ===== hw/rtl/toroidal_life_generation_top_defines.svh =====
// Assertion macros for the toroidal life generation block.
// Used by the port checker; depends on clk and rst in the using scope.
`ifndef TOROIDAL_LIFE_GENERATION_TOP_DEFINES_SVH
`define TOROIDAL_LIFE_GENERATION_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define TLG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlg port check failed");

// next-cycle implication, off during reset
`define TLG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlg port check failed");

// next-cycle implication, also checked through reset
`define TLG_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tlg port check failed");

`endif

// ===== hw/rtl/tlg_pkg.sv =====
// Package for the toroidal life generation block: payload structs, codes
// and the cell control struct. No dependencies.
package tlg_pkg;

  localparam int ROW_IDX_W = 5;
  localparam int SIZE_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int BITS_W    = 32;

  localparam logic [1:0] KIND_TOGGLE  = 2'd0;
  localparam logic [1:0] KIND_CLEAR   = 2'd1;
  localparam logic [1:0] KIND_ADVANCE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;

  localparam logic [SIZE_W-1:0] SIZE_MIN   = 6'd3;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  localparam logic [3:0] LIVE_KEEP  = 4'd2;
  localparam logic [3:0] LIVE_BIRTH = 4'd3;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ROW_IDX_W-1:0] cell_row;
    logic [ROW_IDX_W-1:0] cell_col;
  } tlg_in_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row_index;
    logic [BITS_W-1:0]    row_bits;
    logic                 last_row;
  } tlg_out_t;

  typedef struct packed {
    logic                 clear;
    logic                 shift;
    logic                 toggle;
    logic [ROW_IDX_W-1:0] tail_idx;
    logic [ROW_IDX_W-1:0] toggle_row;
    logic [ROW_IDX_W-1:0] toggle_col;
  } tlg_cell_ctrl_t;

endpackage

// ===== hw/rtl/toroidal_life_generation_top.sv =====
// Toroidal life generation: B3/S23 on a wrapped grid held in a chain of row cells.
// Toggle: row output from S_TOGGLE once the output is free; clear: no output row.
// Advance: one row per cycle for rows in use while the output is not stalled;
// the next input is taken in the cycle after the last row is loaded.
// Row chain shifts one row through the life unit per cycle unless output stalls.
// Synchronous reset clears the grid, sets both sizes to 32 and empties the output.
module toroidal_life_generation_top #(
  parameter int GRID_COLS = 32,
  parameter int GRID_ROWS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tlg_pkg::tlg_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tlg_pkg::tlg_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tlg_pkg::SIZE_W-1:0]      cfg_data
);

  localparam int COL_LIM = (GRID_COLS < 32) ? GRID_COLS : 32;
  localparam int ROW_LIM = (GRID_ROWS < 32) ? GRID_ROWS : 32;
  localparam int IDX_W   = $clog2(ROW_LIM);

  typedef enum logic [1:0] {S_IDLE, S_TOGGLE, S_ADVANCE} state_t;

  state_t                        state;
  logic [tlg_pkg::SIZE_W-1:0]    cols_in_use;
  logic [tlg_pkg::SIZE_W-1:0]    rows_in_use;
  logic [tlg_pkg::SIZE_W-1:0]    cols_eff;
  logic [tlg_pkg::SIZE_W-1:0]    rows_eff;
  logic [tlg_pkg::SIZE_W-1:0]    rows_m1;
  logic [tlg_pkg::ROW_IDX_W-1:0] crow;
  logic [tlg_pkg::ROW_IDX_W-1:0] k;
  logic [tlg_pkg::ROW_IDX_W-1:0] sel;
  logic [COL_LIM-1:0]            prev;
  logic [COL_LIM-1:0]            first;
  logic [COL_LIM-1:0]            rd_row;
  logic [COL_LIM-1:0]            dn_row;
  logic [COL_LIM-1:0]            new_row;
  logic [COL_LIM-1:0]            cell_q    [ROW_LIM];
  logic [COL_LIM-1:0]            cell_next [ROW_LIM];
  logic                          cfg_wr;
  logic                          cfg_hit;
  logic                          accept;
  logic                          in_range;
  logic                          out_free;
  logic                          at_last;
  tlg_pkg::tlg_cell_ctrl_t       ctrl;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && ((cfg_index == tlg_pkg::REG_COLS)
                             || (cfg_index == tlg_pkg::REG_ROWS));

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= tlg_pkg::SIZE_RESET;
      rows_in_use <= tlg_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      if (cfg_index == tlg_pkg::REG_COLS) begin
        cols_in_use <= cfg_data;
      end
      if (cfg_index == tlg_pkg::REG_ROWS) begin
        rows_in_use <= cfg_data;
      end
    end
  end

  always_comb begin
    cols_eff = cols_in_use;
    if (cols_in_use < tlg_pkg::SIZE_MIN) begin
      cols_eff = tlg_pkg::SIZE_MIN;
    end else if (cols_in_use > tlg_pkg::SIZE_W'(COL_LIM)) begin
      cols_eff = tlg_pkg::SIZE_W'(COL_LIM);
    end
    rows_eff = rows_in_use;
    if (rows_in_use < tlg_pkg::SIZE_MIN) begin
      rows_eff = tlg_pkg::SIZE_MIN;
    end else if (rows_in_use > tlg_pkg::SIZE_W'(ROW_LIM)) begin
      rows_eff = tlg_pkg::SIZE_W'(ROW_LIM);
    end
  end

  assign rows_m1  = rows_eff - tlg_pkg::SIZE_W'(1);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_range = ({1'b0, in_data.cell_row} < rows_eff)
                 && ({1'b0, in_data.cell_col} < cols_eff);
  assign at_last  = (k == rows_m1[tlg_pkg::ROW_IDX_W-1:0]);

  assign sel    = (state == S_IDLE) ? rows_m1[tlg_pkg::ROW_IDX_W-1:0] : crow;
  assign rd_row = cell_q[sel[IDX_W-1:0]];
  assign dn_row = at_last ? first : cell_q[1];

  always_comb begin
    ctrl.clear      = cfg_hit || (accept && (in_data.kind == tlg_pkg::KIND_CLEAR));
    ctrl.toggle     = accept && (in_data.kind == tlg_pkg::KIND_TOGGLE) && in_range;
    ctrl.shift      = (state == S_ADVANCE) && out_free;
    ctrl.tail_idx   = rows_m1[tlg_pkg::ROW_IDX_W-1:0];
    ctrl.toggle_row = in_data.cell_row;
    ctrl.toggle_col = in_data.cell_col;
  end

  for (genvar i = 0; i < ROW_LIM; i++) begin : g_cell
    if (i == ROW_LIM - 1) begin : g_end
      assign cell_next[i] = '0;
    end else begin : g_link
      assign cell_next[i] = cell_q[i+1];
    end

    tlg_row_cell #(
      .W   (COL_LIM),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .from_next (cell_next[i]),
      .new_row   (new_row),
      .row       (cell_q[i])
    );
  end

  tlg_life_row #(
    .W (COL_LIM)
  ) u_life (
    .up   (prev),
    .cur  (cell_q[0]),
    .dn   (dn_row),
    .cols (cols_eff),
    .row  (new_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.kind)
              tlg_pkg::KIND_TOGGLE: begin
                if (in_range) begin
                  crow  <= in_data.cell_row;
                  state <= S_TOGGLE;
                end
              end
              tlg_pkg::KIND_ADVANCE: begin
                prev  <= rd_row;
                first <= cell_q[0];
                k     <= '0;
                state <= S_ADVANCE;
              end
              default: begin
              end
            endcase
          end
        end
        S_TOGGLE: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            out_data.row_index <= crow;
            out_data.row_bits  <= tlg_pkg::BITS_W'(rd_row);
            out_data.last_row  <= 1'b1;
            state              <= S_IDLE;
          end
        end
        S_ADVANCE: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            out_data.row_index <= k;
            out_data.row_bits  <= tlg_pkg::BITS_W'(new_row);
            out_data.last_row  <= at_last;
            prev               <= cell_q[0];
            k                  <= k + tlg_pkg::ROW_IDX_W'(1);
            if (at_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/tlg_row_cell.sv =====
// One cell of the row chain: holds one grid row, shifts toward the head,
// toggles or clears on command. Depends on tlg_pkg.
module tlg_row_cell #(
  parameter int W   = 32,
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tlg_pkg::tlg_cell_ctrl_t ctrl,
  input  logic [W-1:0]           from_next,
  input  logic [W-1:0]           new_row,
  output logic [W-1:0]           row
);

  localparam logic [tlg_pkg::ROW_IDX_W-1:0] MY_IDX = tlg_pkg::ROW_IDX_W'(IDX);

  logic [W-1:0] flip;
  logic [W-1:0] row_next;

  always_comb begin
    for (int c = 0; c < W; c++) begin
      flip[c] = (tlg_pkg::ROW_IDX_W'(c) == ctrl.toggle_col);
    end
  end

  always_comb begin
    row_next = row;
    if (ctrl.clear) begin
      row_next = '0;
    end else if (ctrl.shift && (MY_IDX <= ctrl.tail_idx)) begin
      row_next = (MY_IDX == ctrl.tail_idx) ? new_row : from_next;
    end else if (ctrl.toggle && (MY_IDX == ctrl.toggle_row)) begin
      row_next = row ^ flip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else begin
      row <= row_next;
    end
  end

endmodule

// ===== hw/rtl/tlg_life_row.sv =====
// B3/S23 rule for one row: counts the eight wrapped neighbours of every
// column from the rows above, at and below. Depends on tlg_pkg.
module tlg_life_row #(
  parameter int W = 32
) (
  input  logic [W-1:0]              up,
  input  logic [W-1:0]              cur,
  input  logic [W-1:0]              dn,
  input  logic [tlg_pkg::SIZE_W-1:0] cols,
  output logic [W-1:0]              row
);

  localparam int CW = $clog2(W);

  logic [tlg_pkg::SIZE_W-1:0] cols_m1;
  logic [CW-1:0]              last_idx;
  logic                       up_last;
  logic                       cur_last;
  logic                       dn_last;

  assign cols_m1  = cols - tlg_pkg::SIZE_W'(1);
  assign last_idx = cols_m1[CW-1:0];
  assign up_last  = up[last_idx];
  assign cur_last = cur[last_idx];
  assign dn_last  = dn[last_idx];

  for (genvar c = 0; c < W; c++) begin : g_col
    logic       ul, cl, dl, ur, cr, dr, at_end;
    logic [3:0] n;

    assign at_end = (tlg_pkg::SIZE_W'(c) == cols_m1);

    if (c == 0) begin : g_first
      assign ul = up_last;
      assign cl = cur_last;
      assign dl = dn_last;
    end else begin : g_mid
      assign ul = up[c-1];
      assign cl = cur[c-1];
      assign dl = dn[c-1];
    end

    if (c == W - 1) begin : g_last
      assign ur = up[0];
      assign cr = cur[0];
      assign dr = dn[0];
    end else begin : g_inner
      assign ur = at_end ? up[0]  : up[c+1];
      assign cr = at_end ? cur[0] : cur[c+1];
      assign dr = at_end ? dn[0]  : dn[c+1];
    end

    assign n = 4'(ul) + 4'(up[c]) + 4'(ur) + 4'(cl) + 4'(cr)
             + 4'(dl) + 4'(dn[c]) + 4'(dr);

    assign row[c] = (tlg_pkg::SIZE_W'(c) < cols)
                  && ((n == tlg_pkg::LIVE_BIRTH) || ((n == tlg_pkg::LIVE_KEEP) && cur[c]));
  end

endmodule

// ===== hw/rtl/tlg_checker.sv =====
// Port-level checker for toroidal_life_generation_top, bound to the top level.
// Depends on tlg_pkg and toroidal_life_generation_top_defines.svh.
`include "toroidal_life_generation_top_defines.svh"

module tlg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input tlg_pkg::tlg_in_t              in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input tlg_pkg::tlg_out_t             out_data,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [tlg_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [tlg_pkg::SIZE_W-1:0]    cfg_data
);

  `TLG_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !out_valid)
  `TLG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `TLG_ASSERT_NOW(a_busy_mid_sweep, out_valid && !out_data.last_row, in_stall)
  `TLG_ASSERT_NEXT(a_advance_busy, in_valid && !in_stall && (in_data.kind == tlg_pkg::KIND_ADVANCE), in_stall)

endmodule

bind toroidal_life_generation_top tlg_checker u_tlg_checker (.*);
